// File: rtl/clat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CRLF line assembler package
// Shared types, constants and codes for the line assembler with idle timeout.
// ----------------------------------------------------------------------------
package clat_pkg;

    localparam int LEN_W  = 10;
    localparam int IDLE_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] LF_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_CODE = 8'h0D;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 10'd80;
    localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd10;

    // Input operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Line end status codes.
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_CRLF    = 2'd1;
    localparam logic [1:0] END_LEN     = 2'd2;
    localparam logic [1:0] END_TIMEOUT = 2'd3;

    // Register indexes, taken from the word address.
    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] line_byte;
        logic [1:0]        line_end;
        logic              last;
    } result_t;

    // One classified item: an optional released CR ahead of the final result.
    typedef struct packed {
        logic    lead_cr;
        result_t res;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]  max_line_length;
        logic [IDLE_W-1:0] idle_timeout_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/clat_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line assembler front end
// Classifies each accepted item, updates line state, emits up to one command.
// ----------------------------------------------------------------------------
module clat_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire clat_pkg::cfg_t  cfg,
    input  wire logic           item_valid,
    input  wire clat_pkg::item_t item,
    output logic                cmd_valid,
    output clat_pkg::cmd_t       cmd
);

    logic                          cr_pending_reg, cr_pending_next;
    logic [clat_pkg::LEN_W-1:0]    line_count_reg, line_count_next;
    logic [clat_pkg::IDLE_W-1:0]   idle_count_reg, idle_count_next;

    logic [clat_pkg::LEN_W-1:0]    cnt1;
    logic [clat_pkg::LEN_W-1:0]    cnt2;
    logic                          end1;
    logic                          end2;
    logic [clat_pkg::IDLE_W-1:0]   idle_inc;

    always_comb
    begin
        cnt1 = line_count_reg + clat_pkg::LEN_W'(1);
        cnt2 = line_count_reg + clat_pkg::LEN_W'(2);
        end1 = (cnt1 >= cfg.max_line_length) || (cnt1 == '0);
        end2 = (cnt2 >= cfg.max_line_length) || (cnt2 == '0);
        idle_inc = (idle_count_reg == '1) ? idle_count_reg
                                          : idle_count_reg + clat_pkg::IDLE_W'(1);
    end

    always_comb
    begin
        cr_pending_next = cr_pending_reg;
        line_count_next = line_count_reg;
        idle_count_next = idle_count_reg;
        cmd_valid       = 1'b0;
        cmd             = '0;
        cmd.res.last    = 1'b1;

        if (item_valid)
        begin
            if (item.operation == clat_pkg::OP_TICK)
            begin
                if (idle_inc >= cfg.idle_timeout_ticks)
                begin
                    cmd_valid        = 1'b1;
                    cmd.res.line_end = clat_pkg::END_TIMEOUT;
                    cr_pending_next  = 1'b0;
                    line_count_next  = '0;
                    idle_count_next  = '0;
                end
                else
                begin
                    idle_count_next = idle_inc;
                end
            end
            else
            begin
                idle_count_next = '0;
                if (item.rx_byte == clat_pkg::LF_CODE && cr_pending_reg)
                begin
                    cmd_valid        = 1'b1;
                    cmd.res.line_end = clat_pkg::END_CRLF;
                    cr_pending_next  = 1'b0;
                    line_count_next  = '0;
                end
                else if (cr_pending_reg)
                begin
                    // The held CR is released first.
                    cmd_valid         = 1'b1;
                    cmd.res.has_byte  = 1'b1;
                    if (end1)
                    begin
                        cmd.res.line_byte = clat_pkg::CR_CODE;
                        cmd.res.line_end  = clat_pkg::END_LEN;
                        cr_pending_next   = 1'b0;
                        line_count_next   = '0;
                    end
                    else if (item.rx_byte == clat_pkg::CR_CODE)
                    begin
                        cmd.res.line_byte = clat_pkg::CR_CODE;
                        line_count_next   = cnt1;
                    end
                    else
                    begin
                        cmd.lead_cr       = 1'b1;
                        cmd.res.line_byte = item.rx_byte;
                        cmd.res.line_end  = end2 ? clat_pkg::END_LEN : clat_pkg::END_NONE;
                        cr_pending_next   = 1'b0;
                        line_count_next   = end2 ? '0 : cnt2;
                    end
                end
                else if (item.rx_byte == clat_pkg::CR_CODE)
                begin
                    cr_pending_next = 1'b1;
                end
                else
                begin
                    cmd_valid         = 1'b1;
                    cmd.res.has_byte  = 1'b1;
                    cmd.res.line_byte = item.rx_byte;
                    cmd.res.line_end  = end1 ? clat_pkg::END_LEN : clat_pkg::END_NONE;
                    line_count_next   = end1 ? '0 : cnt1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_pending_reg <= 1'b0;
            line_count_reg <= '0;
            idle_count_reg <= '0;
        end
        else
        begin
            cr_pending_reg <= cr_pending_next;
            line_count_reg <= line_count_next;
            idle_count_reg <= idle_count_next;
        end
    end

`ifndef ASSERT_OFF
    // A timeout result always restarts the line completely.
    a_timeout_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.operation == clat_pkg::OP_TICK && cmd_valid) |=>
        (!cr_pending_reg && line_count_reg == '0 && idle_count_reg == '0))
        else $error("timeout did not restart the line");

    // A released CR ahead of a byte needs a held CR and a received byte.
    a_lead_cr_source: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.lead_cr) |->
        (item.operation == clat_pkg::OP_BYTE && cr_pending_reg))
        else $error("released CR without a held CR");
`endif

endmodule
`default_nettype wire

// File: rtl/clat_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line assembler command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module clat_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire clat_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output clat_pkg::cmd_t      rd_data,
    output logic               empty
);

    clat_pkg::cmd_t                mem_reg [clat_pkg::QDEPTH];
    logic [clat_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [clat_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [clat_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;

    localparam logic [clat_pkg::QPTR_W-1:0] LAST_PTR = clat_pkg::QPTR_W'(clat_pkg::QDEPTH - 1);
    localparam logic [clat_pkg::QCNT_W-1:0] DEPTH_CNT = clat_pkg::QCNT_W'(clat_pkg::QDEPTH);

    assign full    = (cnt_reg == DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0
                                                   : wr_ptr_reg + clat_pkg::QPTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0
                                                   : rd_ptr_reg + clat_pkg::QPTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + clat_pkg::QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - clat_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("command queue underflow");
`endif

endmodule
`default_nettype wire

// File: rtl/clat_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line assembler back end
// Expands queued commands into results and holds them in the output register.
// ----------------------------------------------------------------------------
module clat_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire clat_pkg::cmd_t q_head,
    output logic               q_pop,
    output clat_pkg::result_t   result,
    output logic               empty,
    input  wire logic          pop
);

    logic                  out_valid_reg, out_valid_next;
    logic                  cr_sent_reg, cr_sent_next;
    clat_pkg::result_t      out_reg, out_next;
    clat_pkg::result_t      cr_res;
    logic                  load;
    logic                  send_cr;

    always_comb
    begin
        cr_res           = '0;
        cr_res.has_byte  = 1'b1;
        cr_res.line_byte = clat_pkg::CR_CODE;
        cr_res.line_end  = clat_pkg::END_NONE;
        cr_res.last      = 1'b0;

        load    = !out_valid_reg || pop;
        send_cr = q_head.lead_cr && !cr_sent_reg;
        q_pop   = load && !q_empty && !send_cr;

        out_valid_next = out_valid_reg;
        cr_sent_next   = cr_sent_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                cr_sent_next = send_cr;
                out_next     = send_cr ? cr_res : q_head.res;
            end
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cr_sent_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cr_sent_reg   <= cr_sent_next;
        end
    end

`ifndef ASSERT_OFF
    // Once the CR of a command is out, that command stays at the queue head.
    a_cr_sent_head: assert property (@(posedge clk) disable iff (!rst_n)
        cr_sent_reg |-> (!q_empty && q_head.lead_cr))
        else $error("CR sent but command left the queue head");

    // A CR released ahead of a byte is never the last result of its item.
    a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cr_sent_reg |-> (out_valid_reg && !out_reg.last))
        else $error("released CR marked as last");
`endif

endmodule
`default_nettype wire

// File: rtl/crlf_line_assembler_timeout.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CRLF line assembler with idle timeout
// Cuts received bytes into lines on CRLF, a length limit or an idle timeout.
// ----------------------------------------------------------------------------
// The block takes one input transfer per clock cycle while full is low: a
// received byte or one time tick. Each transfer produces zero, one or two
// result transfers; every result carries an optional line byte, a line end
// status and a flag that marks the last result of its input. A CR is held
// back until the next byte arrives, so a CR followed by a byte other than LF
// or CR gives two results unless the released CR fills the line. The front
// end classifies an input in the cycle it is accepted and writes at most one
// command into a four-entry queue; the back end turns each command into its
// results, one per cycle while pop is high, through a registered output
// stage. Inputs with a single result flow at one per cycle while pop is high,
// and an input with two results holds the output for both; the queue absorbs
// such bursts and full rises only when it holds four commands. The two limits
// are set through the configuration port at byte addresses 0 (maximum line
// length, reset 80) and 4 (idle timeout in ticks, reset 10). The user must
// write them only while no transfer is in flight; the block does not check.
// ----------------------------------------------------------------------------
module crlf_line_assembler_timeout (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire clat_pkg::item_t                     item,
    output logic                                    empty,
    input  wire logic                               pop,
    output clat_pkg::result_t                        result,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [clat_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [clat_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clat_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    // Configuration registers.
    clat_pkg::cfg_t  cfg_reg, cfg_next;
    logic           cfg_wr;
    logic           reg_sel;

    // Front to queue and queue to back connections.
    logic           accept;
    logic           cmd_valid;
    clat_pkg::cmd_t  cmd;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    clat_pkg::cmd_t  q_head;

    // The register index is the word address; the low address bits are ignored.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            clat_pkg::REG_MAX_LEN:
            begin
                prdata = clat_pkg::APB_DATA_W'(cfg_reg.max_line_length);
                if (cfg_wr)
                begin
                    cfg_next.max_line_length = pwdata[clat_pkg::LEN_W-1:0];
                end
            end
            clat_pkg::REG_TIMEOUT:
            begin
                prdata = clat_pkg::APB_DATA_W'(cfg_reg.idle_timeout_ticks);
                if (cfg_wr)
                begin
                    cfg_next.idle_timeout_ticks = pwdata[clat_pkg::IDLE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_line_length    <= clat_pkg::MAX_LEN_RESET;
            cfg_reg.idle_timeout_ticks <= clat_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // An input transfer needs room for one command in the queue.
    assign full   = q_full;
    assign accept = push && !q_full;

    clat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (accept),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    clat_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    clat_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
`default_nettype wire

// File: tb/clat_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line assembler checker
// Watches the item, result and configuration channels of the line assembler,
// predicts the results of every accepted item and compares them in order.
// ----------------------------------------------------------------------------
module clat_line_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire logic                            full,
    input  wire clat_pkg::item_t                 item,
    input  wire logic                            empty,
    input  wire logic                            pop,
    input  wire clat_pkg::result_t               result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [clat_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [clat_pkg::APB_DATA_W-1:0] pwdata,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam int MAX_PRINTED = 40;

    // Shadow copy of the limits and of the line state.
    logic [clat_pkg::LEN_W-1:0]  max_len;
    logic [clat_pkg::IDLE_W-1:0] timeout_ticks;
    logic                        cr_held;
    logic [clat_pkg::LEN_W-1:0]  line_len;
    logic [clat_pkg::IDLE_W-1:0] idle_ticks;

    clat_pkg::result_t expected_lines [$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic void restart_line();
        cr_held    = 1'b0;
        line_len   = '0;
        idle_ticks = '0;
    endfunction

    function automatic void append_result(input logic has,
                                          input logic [clat_pkg::BYTE_W-1:0] b,
                                          input logic [1:0] line_end);
        clat_pkg::result_t r;
        r.has_byte  = has;
        r.line_byte = b;
        r.line_end  = line_end;
        r.last      = 1'b0;
        expected_lines.push_back(r);
    endfunction

    // Appends one byte to the line; returns 1 when the length limit ends the line.
    function automatic logic forward_byte(input logic [clat_pkg::BYTE_W-1:0] b);
        logic at_limit;
        line_len = line_len + clat_pkg::LEN_W'(1);
        at_limit = (line_len >= max_len) || (line_len == '0);
        append_result(1'b1, b, at_limit ? clat_pkg::END_LEN : clat_pkg::END_NONE);
        if (at_limit)
        begin
            restart_line();
        end
        return at_limit;
    endfunction

    function automatic void predict_line_results(input clat_pkg::item_t it);
        int                size_at_entry;
        logic              ended;
        clat_pkg::result_t tail;
        size_at_entry = expected_lines.size();
        if (it.operation == clat_pkg::OP_TICK)
        begin
            if (idle_ticks != '1)
            begin
                idle_ticks = idle_ticks + clat_pkg::IDLE_W'(1);
            end
            if (idle_ticks >= timeout_ticks)
            begin
                append_result(1'b0, '0, clat_pkg::END_TIMEOUT);
                restart_line();
            end
        end
        else
        begin
            idle_ticks = '0;
            if (it.rx_byte == clat_pkg::LF_CODE)
            begin
                if (cr_held)
                begin
                    append_result(1'b0, '0, clat_pkg::END_CRLF);
                    restart_line();
                end
                else
                begin
                    void'(forward_byte(clat_pkg::LF_CODE));
                end
            end
            else
            begin
                // A held CR that is not followed by LF goes out first; if it
                // fills the line, the rest of this byte is dropped.
                ended = 1'b0;
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    ended   = forward_byte(clat_pkg::CR_CODE);
                end
                if (!ended)
                begin
                    if (it.rx_byte == clat_pkg::CR_CODE)
                    begin
                        cr_held = 1'b1;
                    end
                    else
                    begin
                        void'(forward_byte(it.rx_byte));
                    end
                end
            end
        end
        if (expected_lines.size() > size_at_entry)
        begin
            tail      = expected_lines.pop_back();
            tail.last = 1'b1;
            expected_lines.push_back(tail);
        end
    endfunction

    task automatic check_result(input clat_pkg::result_t got);
        clat_pkg::result_t want;
        if (expected_lines.size() == 0)
        begin
            report_mismatch("result transfer with nothing expected", got, 0);
        end
        else
        begin
            want = expected_lines.pop_front();
            if (got.has_byte !== want.has_byte)
            begin
                report_mismatch("has_byte", got.has_byte, want.has_byte);
            end
            if (got.line_byte !== want.line_byte)
            begin
                report_mismatch("line_byte", got.line_byte, want.line_byte);
            end
            if (got.line_end !== want.line_end)
            begin
                report_mismatch("line_end", got.line_end, want.line_end);
            end
            if (got.last !== want.last)
            begin
                report_mismatch("last", got.last, want.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len       = clat_pkg::MAX_LEN_RESET;
            timeout_ticks = clat_pkg::TIMEOUT_RESET;
            restart_line();
            expected_lines.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_result(result);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == clat_pkg::REG_MAX_LEN)
                begin
                    max_len = pwdata[clat_pkg::LEN_W-1:0];
                end
                else
                begin
                    timeout_ticks = pwdata[clat_pkg::IDLE_W-1:0];
                end
            end
            if (push && !full)
            begin
                predict_line_results(item);
            end
            outstanding <= expected_lines.size();
        end
    end

endmodule

// File: tb/crlf_line_assembler_timeout_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line assembler testbench
// Drives bytes and ticks into the line assembler under several limit settings
// and idle patterns; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
// The run opens with a short directed sequence at the reset limits and then
// at tiny limits, so that CRLF pairs, lone CR and LF, a CR that fills the
// line, a dropped CR at a timeout and a timeout on an empty line are all hit
// early. After that, each phase programs new limits while the block is idle
// and sends random traffic built mostly from well-formed pieces (text bytes,
// CRLF pairs, CR followed by another byte, tick bursts around the timeout)
// with some noise mixed in. Each phase sets an idle pattern on the item
// and result sides.
// ----------------------------------------------------------------------------
module crlf_line_assembler_timeout_tb;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 200000;

    logic                            clk     = 1'b0;
    logic                            rst_n   = 1'b0;
    logic                            push    = 1'b0;
    clat_pkg::item_t                 item    = '0;
    logic                            pop     = 1'b0;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [clat_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [clat_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic                            full;
    logic                            empty;
    clat_pkg::result_t               result;
    logic [clat_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int mismatches;
    int outstanding;
    int unsigned cycle_count = 0;

    // Idle pattern of the current phase, in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // Timeout currently programmed; it sizes the random tick bursts.
    int unsigned cur_timeout    = 32'(clat_pkg::TIMEOUT_RESET);

    // Limits and idle pattern of each random phase. The zero limits are out of
    // range and must behave like one. Phase five gets random limits at run time.
    int unsigned max_len_plan [N_PHASES] = '{1, 1023, 5, 8, 0, 20, 16, 80};
    int unsigned timeout_plan [N_PHASES] = '{1, 65535, 4, 3, 0, 12, 6, 10};
    int unsigned send_plan    [N_PHASES] = '{0, 76, 0, 36, 0, 76, 36, 0};
    int unsigned stall_plan   [N_PHASES] = '{0, 0, 76, 36, 0, 0, 36, 76};

    crlf_line_assembler_timeout DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    clat_line_checker line_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The result side pops at random; a pop while empty is simply ignored.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic clat_pkg::item_t byte_item(input logic [clat_pkg::BYTE_W-1:0] b);
        clat_pkg::item_t it;
        it.operation = clat_pkg::OP_BYTE;
        it.rx_byte   = b;
        return it;
    endfunction

    // The byte field of a tick carries junk, which the block must ignore.
    function automatic clat_pkg::item_t tick_item();
        clat_pkg::item_t it;
        it.operation = clat_pkg::OP_TICK;
        it.rx_byte   = clat_pkg::BYTE_W'($urandom_range(255));
        return it;
    endfunction

    // Offers one item and holds it until the block takes the transfer; then,
    // in idle phases, leaves push low for a random number of cycles. Push is
    // only lowered in a step that no later raise shares.
    task automatic send_item(input clat_pkg::item_t it);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Stops sending and waits until every expected result has been taken,
    // then lets the block finish items that give no result at all.
    task automatic wait_for_drain();
        push <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access cycle meets pready.
    task automatic write_register(input logic reg_index,
                                  input logic [clat_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Programs both limits. The unused upper data bits carry random junk.
    task automatic program_limits(input int unsigned max_len, input int unsigned timeout);
        logic [clat_pkg::APB_DATA_W-1:0] len_word;
        logic [clat_pkg::APB_DATA_W-1:0] timeout_word;
        len_word                          = $urandom();
        len_word[clat_pkg::LEN_W-1:0]     = max_len[clat_pkg::LEN_W-1:0];
        timeout_word                      = $urandom();
        timeout_word[clat_pkg::IDLE_W-1:0] = timeout[clat_pkg::IDLE_W-1:0];
        write_register(clat_pkg::REG_MAX_LEN, len_word);
        write_register(clat_pkg::REG_TIMEOUT, timeout_word);
        cur_timeout = timeout;
    endtask

    // Random traffic, mostly pieces of real lines with random content.
    task automatic run_random_traffic(input int unsigned target);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        int unsigned burst_max;
        sent      = 0;
        burst_max = (cur_timeout < 38) ? cur_timeout + 2 : 40;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                send_item(byte_item(clat_pkg::BYTE_W'($urandom_range(255))));
                sent += 1;
            end
            else if (pick < 50)
            begin
                send_item(byte_item(clat_pkg::CR_CODE));
                send_item(byte_item(clat_pkg::LF_CODE));
                sent += 2;
            end
            else if (pick < 58)
            begin
                send_item(byte_item(clat_pkg::LF_CODE));
                sent += 1;
            end
            else if (pick < 68)
            begin
                send_item(byte_item(clat_pkg::CR_CODE));
                send_item(byte_item(clat_pkg::BYTE_W'($urandom_range(255))));
                sent += 2;
            end
            else if (pick < 75)
            begin
                send_item(byte_item(clat_pkg::CR_CODE));
                send_item(byte_item(clat_pkg::CR_CODE));
                sent += 2;
            end
            else if (pick < 95)
            begin
                burst = $urandom_range(1, burst_max);
                repeat (burst) send_item(tick_item());
                sent += burst;
            end
            else
            begin
                send_item(byte_item(clat_pkg::CR_CODE));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limits: byte extremes, a lone LF, a CRLF
        // pair, a CR released by an ordinary byte, and a CR released by a
        // second CR, which stays held into the next part.
        send_item(byte_item(8'h00));
        send_item(byte_item(8'hFF));
        send_item(byte_item(clat_pkg::LF_CODE));
        send_item(byte_item(clat_pkg::CR_CODE));
        send_item(byte_item(clat_pkg::LF_CODE));
        send_item(byte_item(clat_pkg::CR_CODE));
        send_item(byte_item(8'h41));
        send_item(byte_item(clat_pkg::CR_CODE));
        send_item(byte_item(clat_pkg::CR_CODE));
        wait_for_drain();

        // Directed part at tiny limits. Two ticks time out the line and drop
        // the held CR. Then a released CR fills the line and the byte behind
        // it is dropped, a second CR releases the first and pairs with an LF, an
        // empty line times out, and a byte between ticks clears the idle count.
        program_limits(3, 2);
        send_item(tick_item());
        send_item(tick_item());
        send_item(byte_item(8'h78));
        send_item(byte_item(8'h79));
        send_item(byte_item(clat_pkg::CR_CODE));
        send_item(byte_item(8'h7A));
        send_item(byte_item(8'h61));
        send_item(byte_item(clat_pkg::CR_CODE));
        send_item(byte_item(clat_pkg::CR_CODE));
        send_item(byte_item(clat_pkg::LF_CODE));
        send_item(tick_item());
        send_item(tick_item());
        send_item(byte_item(8'h71));
        send_item(tick_item());
        send_item(byte_item(8'h72));
        send_item(tick_item());
        send_item(tick_item());

        max_len_plan[5] = $urandom_range(2, 40);
        timeout_plan[5] = $urandom_range(1, 30);

        // Each phase boundary holds the sender back until every expected
        // transfer has come out, so the limits change only on an idle block.
        // The line state carries over, so a long line from one phase can meet
        // a lower limit in the next.
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_for_drain();
            program_limits(max_len_plan[p], timeout_plan[p]);
            send_idle_pct  = send_plan[p];
            recv_stall_pct = stall_plan[p];
            run_random_traffic(ITEMS_PER_PHASE);
        end

        recv_stall_pct = 0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
